// ===== hw/rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg - shared types and constants for the pixel origin / rounded clip
// Register indexes, clip modes, field widths and the payload structs used
// by the pipeline stages and the port checker.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Field widths
  localparam int unsigned COORD_W     = 16;  // pixel_x/y, origin, clip edges
  localparam int unsigned SCREEN_W    = 17;  // screen_x/y
  localparam int unsigned LOCAL_W     = 18;  // screen minus clip edge
  localparam int unsigned SIZE_W      = 15;  // clip width/height
  localparam int unsigned CALC_W      = 16;  // local coordinate plus radius
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned RADIUS_FIELD_W = 8;
  localparam int unsigned RADII_W     = NUM_CORNERS * RADIUS_FIELD_W;

  localparam int unsigned RADIUS_BITS_DEFAULT = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Stream payloads
  localparam int unsigned IN_TDATA_W  = 2 * COORD_W + COLOR_W;            // 64
  localparam int unsigned OUT_BITS    = 2 * SCREEN_W + COLOR_W + 1;       // 67
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;         // 72
  localparam int unsigned OUT_SX_LSB  = 0;
  localparam int unsigned OUT_SY_LSB  = SCREEN_W;
  localparam int unsigned OUT_COL_LSB = 2 * SCREEN_W;
  localparam int unsigned OUT_VIS_BIT = 2 * SCREEN_W + COLOR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_CLIP_MODE    = 3'd2,
    CFG_CLIP_LEFT    = 3'd3,
    CFG_CLIP_TOP     = 3'd4,
    CFG_CLIP_WIDTH   = 3'd5,
    CFG_CLIP_HEIGHT  = 3'd6,
    CFG_CORNER_RADII = 3'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS    = 2'd0,
    MODE_BOX     = 2'd1,
    MODE_ROUNDED = 2'd2
  } clip_mode_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [MODE_W-1:0]         clip_mode;
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_top;
    logic [SIZE_W-1:0]         clip_width;
    logic [SIZE_W-1:0]         clip_height;
    logic [RADII_W-1:0]        corner_radii;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        pixel_color;
    logic signed [COORD_W-1:0] pixel_y;
    logic signed [COORD_W-1:0] pixel_x;
  } pixel_t;

  // Result fields that pass straight through the circle stage
  typedef struct packed {
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic [COLOR_W-1:0]         color;
  } screen_t;

  // Clip decision taken in the geometry stage
  typedef struct packed {
    logic direct_vis;  // visible without a circle test
    logic use_circle;  // visible only if the circle test passes
  } clip_ctl_t;

  // Usable radius width: the radius field masked to RADIUS_BITS
  function automatic int unsigned radius_w(int unsigned rb);
    return (rb < RADIUS_FIELD_W) ? rb : RADIUS_FIELD_W;
  endfunction

endpackage

// ===== hw/rtl/prc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_cfg_regs - configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module prc_cfg_regs
  import prc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:     cfg_d.origin_x     = cfg_wdata_i[COORD_W-1:0];
        CFG_ORIGIN_Y:     cfg_d.origin_y     = cfg_wdata_i[COORD_W-1:0];
        CFG_CLIP_MODE:    cfg_d.clip_mode    = cfg_wdata_i[MODE_W-1:0];
        CFG_CLIP_LEFT:    cfg_d.clip_left    = cfg_wdata_i[COORD_W-1:0];
        CFG_CLIP_TOP:     cfg_d.clip_top     = cfg_wdata_i[COORD_W-1:0];
        CFG_CLIP_WIDTH:   cfg_d.clip_width   = cfg_wdata_i[SIZE_W-1:0];
        CFG_CLIP_HEIGHT:  cfg_d.clip_height  = cfg_wdata_i[SIZE_W-1:0];
        CFG_CORNER_RADII: cfg_d.corner_radii = cfg_wdata_i[RADII_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/prc_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_geom - input register and clip geometry stage
// Add the origin, test the rectangle, pick the first matching corner and
// register its circle offsets for the circle stage.
// ----------------------------------------------------------------------------
module prc_geom
  import prc_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEFAULT,
  localparam int unsigned RW = radius_w(RADIUS_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pixel_t        in_pixel_i,
  output logic          mid_valid_o,
  input  logic          mid_ready_i,
  output screen_t       mid_scr_o,
  output clip_ctl_t     mid_ctl_o,
  output logic [RW-1:0] mid_dx_o,
  output logic [RW-1:0] mid_dy_o,
  output logic [RW-1:0] mid_r_o
);

  // Input register
  logic   in_v_q;
  pixel_t pix_q;
  // Geometry register
  logic          mid_v_q;
  screen_t       scr_q, scr_d;
  clip_ctl_t     ctl_q, ctl_d;
  logic [RW-1:0] dx_q, dx_d, dy_q, dy_d, r_q, r_d;

  logic adv, in_take;

  assign adv        = in_v_q & (~mid_v_q | mid_ready_i);
  assign in_ready_o = ~in_v_q | adv;
  assign in_take    = in_valid_i & in_ready_o;

  // Geometry
  logic signed [LOCAL_W-1:0] lx_full, ly_full;
  logic                      in_rect;
  logic [CALC_W-1:0]         lx, ly, w, h;
  logic [RW-1:0]             rc   [NUM_CORNERS];
  logic [RW-1:0]             dxc  [NUM_CORNERS];
  logic [RW-1:0]             dyc  [NUM_CORNERS];
  logic                      hitc [NUM_CORNERS];
  logic                      hit;

  always_comb begin
    logic [CALC_W-1:0] r16, tx, ty;
    logic              nx, ny;

    scr_d.screen_x = SCREEN_W'(pix_q.pixel_x) + SCREEN_W'(cfg_i.origin_x);
    scr_d.screen_y = SCREEN_W'(pix_q.pixel_y) + SCREEN_W'(cfg_i.origin_y);
    scr_d.color    = pix_q.pixel_color;

    lx_full = LOCAL_W'(scr_d.screen_x) - LOCAL_W'(cfg_i.clip_left);
    ly_full = LOCAL_W'(scr_d.screen_y) - LOCAL_W'(cfg_i.clip_top);
    in_rect = ~lx_full[LOCAL_W-1] & ~ly_full[LOCAL_W-1]
            & (unsigned'(lx_full) < LOCAL_W'(cfg_i.clip_width))
            & (unsigned'(ly_full) < LOCAL_W'(cfg_i.clip_height));

    // only meaningful when inside: local coords then fit the size width
    lx = CALC_W'(lx_full[SIZE_W-1:0]);
    ly = CALC_W'(ly_full[SIZE_W-1:0]);
    w  = CALC_W'(cfg_i.clip_width);
    h  = CALC_W'(cfg_i.clip_height);

    for (int c = 0; c < NUM_CORNERS; c++) begin
      rc[c] = cfg_i.corner_radii[c*RADIUS_FIELD_W +: RW];
      r16   = CALC_W'(rc[c]);
      // even corners sit on the left, corners 0 and 1 on the top
      if (c % 2 == 0) begin
        nx = lx < r16;
        tx = r16 - CALC_W'(1) - lx;
      end else begin
        nx = (lx + r16) >= w;
        tx = lx + r16 - w;
      end
      if (c < 2) begin
        ny = ly < r16;
        ty = r16 - CALC_W'(1) - ly;
      end else begin
        ny = (ly + r16) >= h;
        ty = ly + r16 - h;
      end
      hitc[c] = (rc[c] != '0) & nx & ny;
      dxc[c]  = tx[RW-1:0];
      dyc[c]  = ty[RW-1:0];
    end

    // first matching corner wins: scan from the last so the lowest overrides
    hit  = 1'b0;
    dx_d = '0;
    dy_d = '0;
    r_d  = '0;
    for (int c = NUM_CORNERS - 1; c >= 0; c--) begin
      if (hitc[c]) begin
        hit  = 1'b1;
        dx_d = dxc[c];
        dy_d = dyc[c];
        r_d  = rc[c];
      end
    end

    unique case (cfg_i.clip_mode)
      MODE_PASS: begin
        ctl_d.direct_vis = 1'b1;
        ctl_d.use_circle = 1'b0;
      end
      MODE_BOX: begin
        ctl_d.direct_vis = in_rect;
        ctl_d.use_circle = 1'b0;
      end
      default: begin
        // rounded rect, and the unused fourth code behaves the same
        ctl_d.direct_vis = in_rect & ~hit;
        ctl_d.use_circle = in_rect & hit;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_take | (in_v_q & ~adv);
      mid_v_q <= adv | (mid_v_q & ~mid_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q <= in_pixel_i;
    end
    if (adv) begin
      scr_q <= scr_d;
      ctl_q <= ctl_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      r_q   <= r_d;
    end
  end

  assign mid_valid_o = mid_v_q;
  assign mid_scr_o   = scr_q;
  assign mid_ctl_o   = ctl_q;
  assign mid_dx_o    = dx_q;
  assign mid_dy_o    = dy_q;
  assign mid_r_o     = r_q;

endmodule

// ===== hw/rtl/prc_circle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_circle - corner circle test and result register
// Square the corner offsets, compare against the squared radius and hold
// the finished result for the output channel.
// ----------------------------------------------------------------------------
module prc_circle
  import prc_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEFAULT,
  localparam int unsigned RW = radius_w(RADIUS_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   mid_valid_i,
  output logic                   mid_ready_o,
  input  screen_t                mid_scr_i,
  input  clip_ctl_t              mid_ctl_i,
  input  logic [RW-1:0]          mid_dx_i,
  input  logic [RW-1:0]          mid_dy_i,
  input  logic [RW-1:0]          mid_r_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [2*RW-1:0] dx_sq, dy_sq, r_sq;
  logic [2*RW:0]   dist_sq;
  logic            vis_d;

  logic                  out_v_q;
  logic [OUT_BITS-1:0]   res_q;

  assign dx_sq   = (2*RW)'(mid_dx_i) * (2*RW)'(mid_dx_i);
  assign dy_sq   = (2*RW)'(mid_dy_i) * (2*RW)'(mid_dy_i);
  assign r_sq    = (2*RW)'(mid_r_i) * (2*RW)'(mid_r_i);
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign vis_d   = mid_ctl_i.direct_vis
                 | (mid_ctl_i.use_circle & (dist_sq <= {1'b0, r_sq}));

  assign mid_ready_o = ~out_v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_v_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready_o && mid_valid_i) begin
      res_q <= {vis_d, mid_scr_i.color, mid_scr_i.screen_y, mid_scr_i.screen_x};
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = OUT_TDATA_W'(res_q);

endmodule

// ===== hw/rtl/pixel_origin_rounded_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_origin_rounded_clip - origin offset with rectangle / rounded clip
// Pixel writes enter on the s_axis request channel, are moved by the origin
// offset, clipped, and leave on the m_axis channel with a visible flag.
//
// Usage:
//  - s_axis carries one pixel write per request; m_axis returns exactly one
//    result per request, in order.
//  - Configuration goes through cfg_we_i / cfg_idx_i / cfg_wdata_i; write it
//    only while no request is in flight.
//  - The accepting edge loads the input register; the geometry register
//    (origin add, rectangle and corner pick) and then the result register
//    (corner squares and compare) follow in that order.
//  - Throughput is one request per cycle whenever the result register is
//    free or being drained; all three stages then advance in the same cycle.
//  - When m_axis stalls, the stages keep filling: up to three requests are
//    held before s_axis_tready_o drops. The result register holds its data
//    until taken.
//  - Reset clears all configuration registers (no clipping, zero origin)
//    and empties the pipeline.
// ----------------------------------------------------------------------------
module pixel_origin_rounded_clip
  import prc_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // pixel requests
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [15:0] pixel_x, [31:16] pixel_y, [63:32] pixel_color
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // clipped results
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [16:0] screen_x, [33:17] screen_y, [65:34] color_out, [66] visible,
  // [71:67] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned RW = radius_w(RADIUS_BITS);

  cfg_t          cfg;
  logic          mid_valid, mid_ready;
  screen_t       mid_scr;
  clip_ctl_t     mid_ctl;
  logic [RW-1:0] mid_dx, mid_dy, mid_r;

  // Hold the register file; writes land at the next edge.
  prc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Capture the request, then decide rectangle and corner membership.
  prc_geom #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_pixel_i  (pixel_t'(s_axis_tdata_i)),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_scr_o   (mid_scr),
    .mid_ctl_o   (mid_ctl),
    .mid_dx_o    (mid_dx),
    .mid_dy_o    (mid_dy),
    .mid_r_o     (mid_r)
  );

  // Finish the corner circle test and drive the result channel.
  prc_circle #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_circle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_scr_i   (mid_scr),
    .mid_ctl_i   (mid_ctl),
    .mid_dx_i    (mid_dx),
    .mid_dy_i    (mid_dy),
    .mid_r_i     (mid_r),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/prc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_checker - port-level checks for pixel_origin_rounded_clip
// Track requests in flight and the clip settings seen on the write port.
// ----------------------------------------------------------------------------
module prc_checker
  import prc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_W = 3;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MODE_W-1:0] mode_q;
  logic              empty_x_q, empty_y_q;
  logic              in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      mode_q    <= MODE_PASS;
      empty_x_q <= 1'b1;
      empty_y_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CLIP_MODE) begin
          mode_q <= cfg_wdata_i[MODE_W-1:0];
        end
        if (cfg_idx_i == CFG_CLIP_WIDTH) begin
          empty_x_q <= (cfg_wdata_i[SIZE_W-1:0] == '0);
        end
        if (cfg_idx_i == CFG_CLIP_HEIGHT) begin
          empty_y_q <= (cfg_wdata_i[SIZE_W-1:0] == '0);
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(3))
    else $error("more than three requests in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt_q != '0)
    else $error("result without a request");

  a_none_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && mode_q == MODE_PASS |-> m_axis_tdata_o[OUT_VIS_BIT])
    else $error("pixel clipped with clipping off");

  a_empty_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && mode_q != MODE_PASS && (empty_x_q || empty_y_q)
      |-> !m_axis_tdata_o[OUT_VIS_BIT])
    else $error("pixel passed an empty clip rectangle");

endmodule

bind pixel_origin_rounded_clip prc_checker u_prc_checker (.*);

// ===== bench/pixel_origin_rounded_clip_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_origin_rounded_clip_test - self-checking bench for the rounded clip
// Drives pixel write requests into the block and predicts every result with
// an independent behavioral model of the origin offset and the none, rect
// and rounded-rect clip modes. Results are compared field by field in
// request order. A short directed part hits coordinate extremes, clip edges,
// each corner, the empty rectangle, clip mode three and overlapping radii.
// A long random part then sweeps many register settings with pixels aimed
// at the clip edges and corners. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module pixel_origin_rounded_clip_test;
  import prc_pkg::*;

  localparam int unsigned RADIUS_BITS = RADIUS_BITS_DEFAULT;
  // Mode three has no name in the package; the block treats it as rounded.
  localparam logic [MODE_W-1:0] CLIP_MODE_SPARE = 2'd3;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_PIXELS  = 170;

  typedef struct {
    logic signed [SCREEN_W-1:0] sx;
    logic signed [SCREEN_W-1:0] sy;
    logic [COLOR_W-1:0]         color;
    logic                       visible;
  } clipped_pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Bench copy of the configuration registers, at the block's widths
  logic signed [COORD_W-1:0] origin_x_reg = '0;
  logic signed [COORD_W-1:0] origin_y_reg = '0;
  logic [MODE_W-1:0]         clip_mode_reg = '0;
  logic signed [COORD_W-1:0] clip_left_reg = '0;
  logic signed [COORD_W-1:0] clip_top_reg = '0;
  logic [SIZE_W-1:0]         clip_width_reg = '0;
  logic [SIZE_W-1:0]         clip_height_reg = '0;
  logic [RADII_W-1:0]        corner_radii_reg = '0;

  pixel_t         pixel_requests_q[$];    // requests not yet handed to the driver
  clipped_pixel_t screen_pixels_due[$];   // predicted results, oldest first
  int             mismatches = 0;
  bit             quiet_tail = 1'b0;      // no idling on either side when set
  int             src_idle_left = 0;
  int             sink_idle_left = 0;

  pixel_origin_rounded_clip #(
    .RADIUS_BITS(RADIUS_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    // [15:0] pixel_x, [31:16] pixel_y, [63:32] pixel_color
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    // [16:0] screen_x, [33:17] screen_y, [65:34] color_out, [66] visible
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offset the pixel by the origin, then decide visibility under the current
  // clip mode. Corners are tried top-left, top-right, bottom-left,
  // bottom-right; the first one whose square holds the pixel decides.
  function automatic clipped_pixel_t predict_clip(pixel_t px);
    clipped_pixel_t res;
    longint sx, sy, lx, ly, w, h, r, dx, dy;
    bit     decided, left_side, top_side;
    sx = longint'(px.pixel_x) + longint'(origin_x_reg);
    sy = longint'(px.pixel_y) + longint'(origin_y_reg);
    res.sx = SCREEN_W'(sx);
    res.sy = SCREEN_W'(sy);
    res.color = px.pixel_color;
    lx = sx - longint'(clip_left_reg);
    ly = sy - longint'(clip_top_reg);
    w = longint'(clip_width_reg);
    h = longint'(clip_height_reg);
    if (clip_mode_reg == MODE_PASS) begin
      res.visible = 1'b1;
    end else if (lx < 0 || ly < 0 || lx >= w || ly >= h) begin
      // also covers the empty rectangle: nothing lies inside it
      res.visible = 1'b0;
    end else if (clip_mode_reg == MODE_BOX) begin
      res.visible = 1'b1;
    end else begin
      // rounded rect, and mode three which behaves the same
      res.visible = 1'b1;
      decided = 1'b0;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        r = longint'(corner_radii_reg[RADIUS_FIELD_W*c +: RADIUS_FIELD_W]) &
            ((longint'(1) << RADIUS_BITS) - 1);
        left_side = (c % 2) == 0;
        top_side  = c < 2;
        if (!decided && r > 0 && (left_side ? lx < r : lx >= w - r) &&
            (top_side ? ly < r : ly >= h - r)) begin
          dx = left_side ? r - 1 - lx : lx - (w - r);
          dy = top_side ? r - 1 - ly : ly - (h - r);
          res.visible = (dx * dx + dy * dy) <= r * r;
          decided = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: predict at each accepted request, then either hold valid
  // low for an idle burst or present the next pending pixel. Valid is never
  // dropped while a request is waiting for ready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    logic   next_valid;
    pixel_t next_data;
    next_valid = s_axis_tvalid_i;
    next_data  = s_axis_tdata_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        screen_pixels_due.push_back(predict_clip(s_axis_tdata_i));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_idle_left > 0) begin
          src_idle_left--;
        end else if (pixel_requests_q.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            // idle this cycle and draw the rest of the burst into src_idle_left
            src_idle_left = $urandom_range(0, 2);
          end else begin
            next_valid = 1'b1;
            next_data  = pixel_requests_q.pop_front();
          end
        end
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i  <= next_data;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken result with the oldest prediction,
  // then pick ready for the next cycle with random stall bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    clipped_pixel_t want;
    logic           next_ready;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (screen_pixels_due.size() == 0) begin
        $error("result 0x%0h arrived with no request pending", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = screen_pixels_due.pop_front();
        check_field("screen_x", 32'(want.sx),
                    32'($signed(m_axis_tdata_o[OUT_SX_LSB +: SCREEN_W])));
        check_field("screen_y", 32'(want.sy),
                    32'($signed(m_axis_tdata_o[OUT_SY_LSB +: SCREEN_W])));
        check_field("color_out", want.color, m_axis_tdata_o[OUT_COL_LSB +: COLOR_W]);
        check_field("visible", 32'(want.visible), 32'(m_axis_tdata_o[OUT_VIS_BIT]));
        check_field("pad", '0, 32'(m_axis_tdata_o[OUT_TDATA_W-1:OUT_BITS]));
      end
    end
    next_ready = 1'b1;
    if (sink_idle_left > 0) begin
      sink_idle_left--;
      next_ready = 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      sink_idle_left = $urandom_range(0, 2);
      next_ready = 1'b0;
    end
    m_axis_tready_i <= next_ready;
  end

  // Wait until every request is out and every result is back, then give the
  // three pipeline stages a little extra time.
  task automatic drain();
    do @(negedge clk_i);
    while (pixel_requests_q.size() != 0 || s_axis_tvalid_i ||
           screen_pixels_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register while idle and mirror it, masked to its width.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_ORIGIN_X:     origin_x_reg     = value[COORD_W-1:0];
      CFG_ORIGIN_Y:     origin_y_reg     = value[COORD_W-1:0];
      CFG_CLIP_MODE:    clip_mode_reg    = value[MODE_W-1:0];
      CFG_CLIP_LEFT:    clip_left_reg    = value[COORD_W-1:0];
      CFG_CLIP_TOP:     clip_top_reg     = value[COORD_W-1:0];
      CFG_CLIP_WIDTH:   clip_width_reg   = value[SIZE_W-1:0];
      CFG_CLIP_HEIGHT:  clip_height_reg  = value[SIZE_W-1:0];
      CFG_CORNER_RADII: corner_radii_reg = value[RADII_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_origin(logic [31:0] x, logic [31:0] y);
    write_reg(CFG_ORIGIN_X, x);
    write_reg(CFG_ORIGIN_Y, y);
  endtask

  task automatic set_clip(logic [31:0] mode, logic [31:0] left, logic [31:0] top,
                          logic [31:0] width, logic [31:0] height,
                          logic [31:0] radii);
    write_reg(CFG_CLIP_MODE, mode);
    write_reg(CFG_CLIP_LEFT, left);
    write_reg(CFG_CLIP_TOP, top);
    write_reg(CFG_CLIP_WIDTH, width);
    write_reg(CFG_CLIP_HEIGHT, height);
    write_reg(CFG_CORNER_RADII, radii);
  endtask

  // Queue a pixel that lands on a chosen screen coordinate; fall back to a
  // random coordinate where the origin puts the target out of input range.
  task automatic aim_pixel(int sx, int sy, logic [31:0] color);
    int     px, py;
    pixel_t req;
    px = sx - int'(origin_x_reg);
    py = sy - int'(origin_y_reg);
    req.pixel_color = color;
    req.pixel_x = (px >= -32768 && px <= 32767) ? COORD_W'(px) : COORD_W'($urandom());
    req.pixel_y = (py >= -32768 && py <= 32767) ? COORD_W'(py) : COORD_W'($urandom());
    pixel_requests_q.push_back(req);
  endtask

  // Offset from a clip edge: mostly near the near or far edge, where the
  // corner squares live, sometimes anywhere across the span.
  function automatic int edge_offset(int span);
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, span + 7) - 4;
      1:       return $urandom_range(0, 40) - 4;
      default: return span + 3 - $urandom_range(0, 40);
    endcase
  endfunction

  initial begin : stimulus
    logic [MODE_W-1:0] mode;
    int                left, top, width, height;
    logic [31:0]       radii;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no clip, zero origin. Push the input extremes through.
    aim_pixel(-32768, -32768, 32'h0000_0000);
    aim_pixel(32767, 32767, 32'hFFFF_FFFF);
    aim_pixel(0, 0, 32'hA5A5_5A5A);
    aim_pixel(-1, 1, 32'h5A5A_A5A5);

    // Extreme origins drive the screen coordinates to both ends.
    set_origin(-32768, 32767);
    aim_pixel(-65536, -1, 32'h1234_5678);
    aim_pixel(-1, 65534, 32'h8765_4321);
    set_origin(32767, -32768);
    aim_pixel(65534, -65536, 32'hDEAD_BEEF);
    aim_pixel(0, 0, 32'h0F0F_F0F0);

    // Plain rectangle: probe one pixel on each side of every edge.
    set_origin(100, -200);
    set_clip(MODE_BOX, 10, 20, 30, 15, 0);
    aim_pixel(9, 20, $urandom());
    aim_pixel(10, 20, $urandom());
    aim_pixel(39, 20, $urandom());
    aim_pixel(40, 20, $urandom());
    aim_pixel(10, 19, $urandom());
    aim_pixel(10, 34, $urandom());
    aim_pixel(10, 35, $urandom());

    // Rounded rect, radii TL 5, TR 8, BL 1, BR 4: inside and outside arcs.
    set_clip(MODE_ROUNDED, 10, 20, 30, 15, {8'd4, 8'd1, 8'd8, 8'd5});
    aim_pixel(10, 20, $urandom());
    aim_pixel(11, 21, $urandom());
    aim_pixel(39, 20, $urandom());
    aim_pixel(10, 34, $urandom());
    aim_pixel(39, 34, $urandom());
    aim_pixel(36, 31, $urandom());

    // Mode three with every radius at its maximum: corner squares overlap.
    set_clip(CLIP_MODE_SPARE, 10, 20, 30, 15, 32'hFFFF_FFFF);
    aim_pixel(10, 20, $urandom());
    aim_pixel(25, 27, $urandom());

    // Empty rectangle clips everything.
    set_clip(MODE_BOX, 10, 20, 0, 15, 0);
    aim_pixel(10, 20, $urandom());

    // Widest rectangle at the far edges of the coordinate range.
    set_origin(32767, 0);
    set_clip(MODE_BOX, 32767, -32768, 32767, 32767, 0);
    aim_pixel(65533, -1, $urandom());
    aim_pixel(65533, -2, $urandom());

    // Random settings, each followed by a batch of pixels aimed at the clip
    // edges and corners with some fully random noise mixed in.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       mode = MODE_PASS;
        1:       mode = CLIP_MODE_SPARE;
        2, 3, 4: mode = MODE_BOX;
        default: mode = MODE_ROUNDED;
      endcase
      left = ($urandom_range(0, 5) == 0) ? int'($signed(16'($urandom())))
                                         : $urandom_range(0, 200) - 100;
      top  = ($urandom_range(0, 5) == 0) ? int'($signed(16'($urandom())))
                                         : $urandom_range(0, 200) - 100;
      case ($urandom_range(0, 7))
        0:       width = 0;
        1:       width = 32767;
        2:       width = $urandom_range(0, 32767);
        default: width = $urandom_range(1, 48);
      endcase
      case ($urandom_range(0, 7))
        0:       height = 0;
        1:       height = 32767;
        2:       height = $urandom_range(0, 32767);
        default: height = $urandom_range(1, 48);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        radii = $urandom();
      end else begin
        for (int c = 0; c < NUM_CORNERS; c++)
          radii[RADIUS_FIELD_W*c +: RADIUS_FIELD_W] =
              ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
      end
      // Junk in the unused upper bits must be dropped by the block.
      if ($urandom_range(0, 3) == 0)
        set_origin($urandom(), $urandom());
      else
        set_origin({16'($urandom()), 16'($urandom_range(0, 400) - 200)},
                   {16'($urandom()), 16'($urandom_range(0, 400) - 200)});
      set_clip({30'($urandom()), mode}, {16'($urandom()), 16'(left)},
               {16'($urandom()), 16'(top)}, {17'($urandom()), 15'(width)},
               {17'($urandom()), 15'(height)}, radii);

      // Run the last batch back to back on both sides.
      quiet_tail = (phase == RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if ($urandom_range(0, 6) == 0)
          pixel_requests_q.push_back({32'($urandom()), 16'($urandom()), 16'($urandom())});
        else
          aim_pixel(left + edge_offset(width), top + edge_offset(height), $urandom());
      end
    end

    drain();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/prc_pkg.sv
hw/rtl/prc_cfg_regs.sv
hw/rtl/prc_geom.sv
hw/rtl/prc_circle.sv
hw/rtl/pixel_origin_rounded_clip.sv
hw/rtl/prc_checker.sv
bench/pixel_origin_rounded_clip_test.sv
